### rtl/core/dpes_pkg.sv
package dpes_pkg;

  // Default sizes of the graph stores
  localparam int DefMaxNodes = 256;
  localparam int DefMaxEdges = 4096;

  // Fixed field widths
  localparam int OpW      = 2;
  localparam int IndexW   = 12;
  localparam int NodeFldW = 8;
  localparam int EdgeW    = 2 * NodeFldW;
  localparam int StatusW  = 3;
  localparam int CountW   = 16;
  localparam int CfgW     = 13;

  localparam logic [CfgW-1:0] EdgeCountReset = 13'd4096;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_LOAD = 2'd0,
    OP_SWAP = 2'd1,
    OP_READ = 2'd2
  } dpes_op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 3'd0,
    ST_SWAPPED = 3'd1,
    ST_SHARED  = 3'd2,
    ST_EXISTS  = 3'd3,
    ST_RANGE   = 3'd4
  } dpes_status_e;

  // Controller states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LOAD_1,
    S_LOAD_2,
    S_RD_ADDR,
    S_RD_DATA,
    S_SW_RD_I,
    S_SW_RD_J,
    S_SW_DATA_J,
    S_SW_TEST,
    S_SW_ADJ_2,
    S_SW_ADJ_3,
    S_WR_0,
    S_WR_1,
    S_WR_2,
    S_WR_3,
    S_WR_4,
    S_WR_5,
    S_WR_6,
    S_WR_7,
    S_DONE_LOAD,
    S_DONE_READ,
    S_DONE_SWAPPED,
    S_DONE_SHARED,
    S_DONE_EXISTS,
    S_DONE_RANGE
  } dpes_state_e;

  // Adjacency bitmap address select
  typedef enum logic [3:0] {
    ADJ_CLEAR,
    ADJ_LOAD_AB,
    ADJ_LOAD_BA,
    ADJ_V1V2,
    ADJ_V2V1,
    ADJ_V3V4,
    ADJ_V4V3,
    ADJ_V1Q,
    ADJ_QV1,
    ADJ_V2S,
    ADJ_SV2
  } dpes_adj_sel_e;

  // Edge list address select
  typedef enum logic {
    EA_FIRST,
    EA_SECOND
  } dpes_edge_addr_e;

  // Edge list write data select
  typedef enum logic [1:0] {
    ED_LOAD,
    ED_NEW_FIRST,
    ED_NEW_SECOND
  } dpes_edge_data_e;

  // Result endpoint select
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_LOAD,
    RES_FIRST,
    RES_NEW
  } dpes_res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic            capture;
    logic            clr_step;
    logic            edge_we;
    dpes_edge_addr_e edge_addr;
    dpes_edge_data_e edge_data;
    logic            latch_first;
    logic            latch_second;
    logic            adj_we;
    logic            adj_wbit;
    dpes_adj_sel_e   adj_sel;
    logic            exist_load;
    logic            count_up;
    logic            push;
    dpes_res_sel_e   res_sel;
    dpes_status_e    res_status;
  } dpes_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic           first_ok;
    logic           both_ok;
    logic           nodes_ok;
    logic           shared;
    logic           exists;
    logic           clear_last;
    logic           out_free;
  } dpes_stat_t;

endpackage

### rtl/core/dpes_ram.sv
module dpes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/dpes_ctrl.sv
module dpes_ctrl import dpes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dpes_stat_t stat_i,
  output dpes_cmd_t  cmd_o
);

  dpes_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:     if (stat_i.clear_last) state_d = S_IDLE;
      S_IDLE:      if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        case (stat_i.opcode)
          OP_LOAD: state_d = (stat_i.first_ok && stat_i.nodes_ok) ? S_LOAD_1 : S_DONE_RANGE;
          OP_READ: state_d = stat_i.first_ok ? S_RD_ADDR : S_DONE_RANGE;
          OP_SWAP: state_d = stat_i.both_ok ? S_SW_RD_I : S_DONE_RANGE;
          default: state_d = S_DONE_RANGE;
        endcase
      end
      S_LOAD_1:    state_d = S_LOAD_2;
      S_LOAD_2:    state_d = S_DONE_LOAD;
      S_RD_ADDR:   state_d = S_RD_DATA;
      S_RD_DATA:   state_d = S_DONE_READ;
      S_SW_RD_I:   state_d = S_SW_RD_J;
      S_SW_RD_J:   state_d = S_SW_DATA_J;
      S_SW_DATA_J: state_d = S_SW_TEST;
      S_SW_TEST:   state_d = stat_i.shared ? S_DONE_SHARED : S_SW_ADJ_2;
      S_SW_ADJ_2:  state_d = S_SW_ADJ_3;
      S_SW_ADJ_3:  state_d = stat_i.exists ? S_DONE_EXISTS : S_WR_0;
      S_WR_0:      state_d = S_WR_1;
      S_WR_1:      state_d = S_WR_2;
      S_WR_2:      state_d = S_WR_3;
      S_WR_3:      state_d = S_WR_4;
      S_WR_4:      state_d = S_WR_5;
      S_WR_5:      state_d = S_WR_6;
      S_WR_6:      state_d = S_WR_7;
      S_WR_7:      state_d = S_DONE_SWAPPED;
      S_DONE_LOAD, S_DONE_READ, S_DONE_SWAPPED,
      S_DONE_SHARED, S_DONE_EXISTS, S_DONE_RANGE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.edge_addr  = EA_FIRST;
    cmd_o.edge_data  = ED_LOAD;
    cmd_o.adj_sel    = ADJ_CLEAR;
    cmd_o.res_sel    = RES_ZERO;
    cmd_o.res_status = ST_DONE;
    in_stall_o       = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cmd_o.adj_we   = 1'b1;
        cmd_o.clr_step = 1'b1;
      end
      S_IDLE:      cmd_o.capture = in_valid_i;
      S_LOAD_1: begin
        cmd_o.edge_we  = 1'b1;
        cmd_o.adj_we   = 1'b1;
        cmd_o.adj_wbit = 1'b1;
        cmd_o.adj_sel  = ADJ_LOAD_AB;
      end
      S_LOAD_2: begin
        cmd_o.adj_we   = 1'b1;
        cmd_o.adj_wbit = 1'b1;
        cmd_o.adj_sel  = ADJ_LOAD_BA;
      end
      S_RD_DATA:   cmd_o.latch_first = 1'b1;
      S_SW_RD_J: begin
        cmd_o.latch_first = 1'b1;
        cmd_o.edge_addr   = EA_SECOND;
      end
      S_SW_DATA_J: cmd_o.latch_second = 1'b1;
      S_SW_TEST:   cmd_o.adj_sel = ADJ_V1Q;
      S_SW_ADJ_2: begin
        cmd_o.exist_load = 1'b1;
        cmd_o.adj_sel    = ADJ_V2S;
      end
      // clear the old edges, then set the new ones
      S_WR_0: begin
        cmd_o.adj_we    = 1'b1;
        cmd_o.adj_sel   = ADJ_V1V2;
        cmd_o.edge_we   = 1'b1;
        cmd_o.edge_data = ED_NEW_FIRST;
      end
      S_WR_1: begin
        cmd_o.adj_we    = 1'b1;
        cmd_o.adj_sel   = ADJ_V2V1;
        cmd_o.edge_we   = 1'b1;
        cmd_o.edge_addr = EA_SECOND;
        cmd_o.edge_data = ED_NEW_SECOND;
      end
      S_WR_2: begin
        cmd_o.adj_we  = 1'b1;
        cmd_o.adj_sel = ADJ_V3V4;
      end
      S_WR_3: begin
        cmd_o.adj_we  = 1'b1;
        cmd_o.adj_sel = ADJ_V4V3;
      end
      S_WR_4: begin
        cmd_o.adj_we   = 1'b1;
        cmd_o.adj_wbit = 1'b1;
        cmd_o.adj_sel  = ADJ_V1Q;
      end
      S_WR_5: begin
        cmd_o.adj_we   = 1'b1;
        cmd_o.adj_wbit = 1'b1;
        cmd_o.adj_sel  = ADJ_QV1;
      end
      S_WR_6: begin
        cmd_o.adj_we   = 1'b1;
        cmd_o.adj_wbit = 1'b1;
        cmd_o.adj_sel  = ADJ_V2S;
      end
      S_WR_7: begin
        cmd_o.adj_we   = 1'b1;
        cmd_o.adj_wbit = 1'b1;
        cmd_o.adj_sel  = ADJ_SV2;
        cmd_o.count_up = 1'b1;
      end
      S_DONE_LOAD: begin
        cmd_o.push    = stat_i.out_free;
        cmd_o.res_sel = RES_LOAD;
      end
      S_DONE_READ: begin
        cmd_o.push    = stat_i.out_free;
        cmd_o.res_sel = RES_FIRST;
      end
      S_DONE_SWAPPED: begin
        cmd_o.push       = stat_i.out_free;
        cmd_o.res_sel    = RES_NEW;
        cmd_o.res_status = ST_SWAPPED;
      end
      S_DONE_SHARED: begin
        cmd_o.push       = stat_i.out_free;
        cmd_o.res_sel    = RES_FIRST;
        cmd_o.res_status = ST_SHARED;
      end
      S_DONE_EXISTS: begin
        cmd_o.push       = stat_i.out_free;
        cmd_o.res_sel    = RES_FIRST;
        cmd_o.res_status = ST_EXISTS;
      end
      S_DONE_RANGE: begin
        cmd_o.push       = stat_i.out_free;
        cmd_o.res_status = ST_RANGE;
      end
      default: ;
    endcase
  end

  // State register; reset starts the bitmap clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/dpes_datapath.sv
module dpes_datapath import dpes_pkg::*; #(
  parameter int MAX_NODES = DefMaxNodes,
  parameter int MAX_EDGES = DefMaxEdges
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpes_cmd_t           cmd_i,
  output dpes_stat_t          stat_o,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_edge_count_i,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [IndexW-1:0]   first_edge_index_i,
  input  logic [IndexW-1:0]   second_edge_index_i,
  input  logic                orientation_i,
  input  logic [NodeFldW-1:0] load_node_a_i,
  input  logic [NodeFldW-1:0] load_node_b_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [StatusW-1:0]  status_o,
  output logic [NodeFldW-1:0] edge_node_a_o,
  output logic [NodeFldW-1:0] edge_node_b_o,
  output logic [CountW-1:0]   swap_total_o
);

  // Store sizes: node ids and indices never exceed their field widths
  localparam int NodeDepth = (MAX_NODES < (1 << NodeFldW)) ? MAX_NODES : (1 << NodeFldW);
  localparam int NodeW     = $clog2(NodeDepth);
  localparam int AdjW      = 2 * NodeW;
  localparam int AdjDepth  = 1 << AdjW;
  localparam int EdgeDepth = (MAX_EDGES < (1 << IndexW)) ? MAX_EDGES : (1 << IndexW);
  localparam int EdgeAddrW = (EdgeDepth > 1) ? $clog2(EdgeDepth) : 1;

  localparam logic [16:0]   MaxEdgesL = 17'(MAX_EDGES);
  localparam logic [CfgW:0] MaxNodesL = (CfgW + 1)'(MAX_NODES);

  logic [CfgW-1:0]     edge_count_q;
  logic [OpW-1:0]      op_q;
  logic [IndexW-1:0]   i_q, j_q;
  logic                orient_q;
  logic [NodeFldW-1:0] la_q, lb_q;
  logic [NodeFldW-1:0] v1_q, v2_q, v3_q, v4_q;
  logic                exist_q;
  logic [CountW-1:0]   count_q;
  logic [AdjW-1:0]     clr_addr_q;
  logic                out_valid_q;
  logic [StatusW-1:0]  res_status_q;
  logic [NodeFldW-1:0] res_a_q, res_b_q;
  logic [CountW-1:0]   res_total_q;

  logic [NodeFldW-1:0]  q_node, s_node;
  logic [EdgeW-1:0]     edge_wdata, edge_rdata;
  logic [EdgeAddrW-1:0] edge_addr;
  logic [AdjW-1:0]      adj_addr;
  logic                 adj_rdata;
  logic                 out_free;
  logic [NodeFldW-1:0]  res_a_d, res_b_d;

  function automatic logic [AdjW-1:0] adj_pos(logic [NodeFldW-1:0] a, logic [NodeFldW-1:0] b);
    return {a[NodeW-1:0], b[NodeW-1:0]};
  endfunction

  // New partners: edges v1-q and v2-s
  assign q_node = orient_q ? v3_q : v4_q;
  assign s_node = orient_q ? v4_q : v3_q;

  // Edge list port
  always_comb begin
    case (cmd_i.edge_addr)
      EA_FIRST:  edge_addr = i_q[EdgeAddrW-1:0];
      EA_SECOND: edge_addr = j_q[EdgeAddrW-1:0];
      default:   edge_addr = i_q[EdgeAddrW-1:0];
    endcase
    case (cmd_i.edge_data)
      ED_LOAD:       edge_wdata = {la_q, lb_q};
      ED_NEW_FIRST:  edge_wdata = {v1_q, q_node};
      ED_NEW_SECOND: edge_wdata = orient_q ? {v2_q, v4_q} : {v3_q, v2_q};
      default:       edge_wdata = {la_q, lb_q};
    endcase
  end

  dpes_ram #(
    .WIDTH (EdgeW),
    .DEPTH (EdgeDepth)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.edge_we),
    .addr_i  (edge_addr),
    .wdata_i (edge_wdata),
    .rdata_o (edge_rdata)
  );

  // Adjacency bitmap port
  always_comb begin
    case (cmd_i.adj_sel)
      ADJ_CLEAR:   adj_addr = clr_addr_q;
      ADJ_LOAD_AB: adj_addr = adj_pos(la_q, lb_q);
      ADJ_LOAD_BA: adj_addr = adj_pos(lb_q, la_q);
      ADJ_V1V2:    adj_addr = adj_pos(v1_q, v2_q);
      ADJ_V2V1:    adj_addr = adj_pos(v2_q, v1_q);
      ADJ_V3V4:    adj_addr = adj_pos(v3_q, v4_q);
      ADJ_V4V3:    adj_addr = adj_pos(v4_q, v3_q);
      ADJ_V1Q:     adj_addr = adj_pos(v1_q, q_node);
      ADJ_QV1:     adj_addr = adj_pos(q_node, v1_q);
      ADJ_V2S:     adj_addr = adj_pos(v2_q, s_node);
      ADJ_SV2:     adj_addr = adj_pos(s_node, v2_q);
      default:     adj_addr = clr_addr_q;
    endcase
  end

  dpes_ram #(
    .WIDTH (1),
    .DEPTH (AdjDepth)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.adj_we),
    .addr_i  (adj_addr),
    .wdata_i (cmd_i.adj_wbit),
    .rdata_o (adj_rdata)
  );

  // Status back to the controller
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_o            = '0;
    stat_o.opcode     = op_q;
    stat_o.first_ok   = ({1'b0, i_q} < edge_count_q) && ({5'd0, i_q} < MaxEdgesL);
    stat_o.both_ok    = stat_o.first_ok && ({1'b0, j_q} < edge_count_q)
                        && ({5'd0, j_q} < MaxEdgesL);
    stat_o.nodes_ok   = ({6'd0, la_q} < MaxNodesL) && ({6'd0, lb_q} < MaxNodesL);
    stat_o.shared     = (v1_q == v3_q) || (v1_q == v4_q) || (v2_q == v3_q) || (v2_q == v4_q);
    stat_o.exists     = exist_q || adj_rdata;
    stat_o.clear_last = &clr_addr_q;
    stat_o.out_free   = out_free;
  end

  // Request fields and edge endpoints
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= opcode_i;
      i_q      <= first_edge_index_i;
      j_q      <= second_edge_index_i;
      orient_q <= orientation_i;
      la_q     <= load_node_a_i;
      lb_q     <= load_node_b_i;
    end
    if (cmd_i.latch_first) begin
      v1_q <= edge_rdata[EdgeW-1:NodeFldW];
      v2_q <= edge_rdata[NodeFldW-1:0];
    end
    if (cmd_i.latch_second) begin
      v3_q <= edge_rdata[EdgeW-1:NodeFldW];
      v4_q <= edge_rdata[NodeFldW-1:0];
    end
    if (cmd_i.exist_load) begin
      exist_q <= adj_rdata;
    end
  end

  // Result endpoints
  always_comb begin
    case (cmd_i.res_sel)
      RES_ZERO: begin
        res_a_d = '0;
        res_b_d = '0;
      end
      RES_LOAD: begin
        res_a_d = la_q;
        res_b_d = lb_q;
      end
      RES_FIRST: begin
        res_a_d = v1_q;
        res_b_d = v2_q;
      end
      RES_NEW: begin
        res_a_d = v1_q;
        res_b_d = q_node;
      end
      default: begin
        res_a_d = '0;
        res_b_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      res_status_q <= cmd_i.res_status;
      res_a_q      <= res_a_d;
      res_b_q      <= res_b_d;
      res_total_q  <= count_q;
    end
  end

  // Config, swap counter, clear sweep, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= EdgeCountReset;
      count_q      <= '0;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        edge_count_q <= cfg_edge_count_i;
      end
      if (cmd_i.count_up && (count_q != '1)) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign edge_node_a_o = res_a_q;
  assign edge_node_b_o = res_b_q;
  assign swap_total_o  = res_total_q;

endmodule

### rtl/core/degree_preserving_edge_swap.sv
// Degree-preserving edge swap engine. The graph is held as an edge list
// (single-port RAM, min(MAX_EDGES,4096) x 16 bits, entries of {node_a, node_b})
// and a symmetric adjacency bitmap (single-port 1-bit RAM). After reset the
// block clears all 2**(2*ceil(log2(min(MAX_NODES,256)))) bitmap bits (65536
// at the default size) one bit per cycle, and stalls the input until that
// pass ends; configuration writes are taken at any time. One item is in work
// at a time, and the next is taken while a finished result waits on the
// output register. A swap is bounded by the one bitmap port: two reads for
// the existence check and eight single-bit writes, while the edge list port
// reads two entries and writes two.
module degree_preserving_edge_swap import dpes_pkg::*; #(
  parameter int MAX_NODES = DefMaxNodes,
  parameter int MAX_EDGES = DefMaxEdges
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_edge_count_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [IndexW-1:0]   first_edge_index_i,
  input  logic [IndexW-1:0]   second_edge_index_i,
  input  logic                orientation_i,
  input  logic [NodeFldW-1:0] load_node_a_i,
  input  logic [NodeFldW-1:0] load_node_b_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StatusW-1:0]  status_o,
  output logic [NodeFldW-1:0] edge_node_a_o,
  output logic [NodeFldW-1:0] edge_node_b_o,
  output logic [CountW-1:0]   swap_total_o
);

  dpes_cmd_t  cmd;
  dpes_stat_t stat;

  assign cfg_ready_o = 1'b1;

  dpes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dpes_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_edge_count_i    (cfg_edge_count_i),
    .opcode_i            (opcode_i),
    .first_edge_index_i  (first_edge_index_i),
    .second_edge_index_i (second_edge_index_i),
    .orientation_i       (orientation_i),
    .load_node_a_i       (load_node_a_i),
    .load_node_b_i       (load_node_b_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .status_o            (status_o),
    .edge_node_a_o       (edge_node_a_o),
    .edge_node_b_o       (edge_node_b_o),
    .swap_total_o        (swap_total_o)
  );

  // A result is only written into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> stat.out_free)
    else $error("result pushed over a pending result");

  // Edge list writes only go to an index that passed the range check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.edge_we |-> stat.first_ok)
    else $error("edge list write to an out-of-range index");

  // Range rejects carry zero endpoints
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_RANGE)) |-> ((edge_node_a_o == '0) && (edge_node_b_o == '0)))
    else $error("range reject with nonzero endpoints");

  // A successful swap has been counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_SWAPPED)) |-> (swap_total_o != '0))
    else $error("swap reported but swap total is zero");

endmodule

### tb/sv/tb_degree_preserving_edge_swap.sv
module tb_degree_preserving_edge_swap;
  timeunit 1ns;
  timeprecision 1ps;

  import dpes_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int NumDirRows    = 24;
  localparam int NumPhases     = 8;
  localparam int LoadWindow    = 64;
  localparam int MaxReports    = 10;
  localparam int EndSlack      = 40;
  // covers the bitmap clear after reset with room to spare
  localparam int unsigned WatchdogLimit = 200000;

  // One request as it goes on the input ports
  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [IndexW-1:0]   first_idx;
    logic [IndexW-1:0]   second_idx;
    logic                orient;
    logic [NodeFldW-1:0] node_a;
    logic [NodeFldW-1:0] node_b;
  } graph_req_t;

  // One result as it comes off the output ports
  typedef struct packed {
    dpes_status_e        status;
    logic [NodeFldW-1:0] node_a;
    logic [NodeFldW-1:0] node_b;
    logic [CountW-1:0]   total;
  } swap_result_t;

  // Directed stimulus row, with a hand-written result where one is given
  typedef struct packed {
    graph_req_t   req;
    logic         typed;
    swap_result_t res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_edge_count_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OpW-1:0]      opcode_i = '0;
  logic [IndexW-1:0]   first_edge_index_i = '0;
  logic [IndexW-1:0]   second_edge_index_i = '0;
  logic                orientation_i = 1'b0;
  logic [NodeFldW-1:0] load_node_a_i = '0;
  logic [NodeFldW-1:0] load_node_b_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [NodeFldW-1:0] edge_node_a_o;
  logic [NodeFldW-1:0] edge_node_b_o;
  logic [CountW-1:0]   swap_total_o;

  // Shadow copy of the graph and the register
  logic [EdgeW-1:0]  edge_tbl [DefMaxEdges];
  bit                adj_map [DefMaxNodes][DefMaxNodes];
  bit                loaded_flag [DefMaxEdges];
  int                loaded_list [$];
  logic [CountW-1:0] swap_count = '0;
  logic [CfgW-1:0]   edge_count_cfg = EdgeCountReset;

  swap_result_t expected_q [$];
  dir_row_t     dir_tab [NumDirRows];

  int          phase_edges [NumPhases] = '{4096, 1, 2, 37, 4096, 300, 4095, 4096};
  int          phase_len [NumPhases]   = '{300, 30, 40, 200, 300, 200, 200, 230};
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 56;
  int          items_sent = 0;
  int          fail_count = 0;
  int unsigned quiet_cycles = 0;

  degree_preserving_edge_swap u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_edge_count_i   (cfg_edge_count_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .first_edge_index_i (first_edge_index_i),
    .second_edge_index_i(second_edge_index_i),
    .orientation_i      (orientation_i),
    .load_node_a_i      (load_node_a_i),
    .load_node_b_i      (load_node_b_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .edge_node_a_o      (edge_node_a_o),
    .edge_node_b_o      (edge_node_b_o),
    .swap_total_o       (swap_total_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic bit index_in_use(logic [IndexW-1:0] idx);
    return {1'b0, idx} < edge_count_cfg;
  endfunction

  // Applies one request to the shadow graph and returns the result it gives
  function automatic swap_result_t apply_graph_op(graph_req_t r);
    swap_result_t res;
    logic [NodeFldW-1:0] v1, v2, v3, v4, q, s;
    res.status = ST_RANGE;
    res.node_a = '0;
    res.node_b = '0;
    case (r.op)
      OP_LOAD: begin
        if (index_in_use(r.first_idx)) begin
          edge_tbl[r.first_idx] = {r.node_a, r.node_b};
          adj_map[r.node_a][r.node_b] = 1'b1;
          adj_map[r.node_b][r.node_a] = 1'b1;
          if (!loaded_flag[r.first_idx]) begin
            loaded_flag[r.first_idx] = 1'b1;
            loaded_list.insert(loaded_list.size(), int'(r.first_idx));
          end
          res.status = ST_DONE;
          res.node_a = r.node_a;
          res.node_b = r.node_b;
        end
      end
      OP_READ: begin
        if (index_in_use(r.first_idx)) begin
          {res.node_a, res.node_b} = edge_tbl[r.first_idx];
          res.status = ST_DONE;
        end
      end
      OP_SWAP: begin
        if (index_in_use(r.first_idx) && index_in_use(r.second_idx)) begin
          {v1, v2} = edge_tbl[r.first_idx];
          {v3, v4} = edge_tbl[r.second_idx];
          // new edges are v1-q and v2-s
          q = r.orient ? v3 : v4;
          s = r.orient ? v4 : v3;
          if (v1 == v3 || v1 == v4 || v2 == v3 || v2 == v4) begin
            res.status = ST_SHARED;
          end else if (adj_map[v1][q] || adj_map[v2][s]) begin
            res.status = ST_EXISTS;
          end else begin
            adj_map[v1][v2] = 1'b0;
            adj_map[v2][v1] = 1'b0;
            adj_map[v3][v4] = 1'b0;
            adj_map[v4][v3] = 1'b0;
            adj_map[v1][q] = 1'b1;
            adj_map[q][v1] = 1'b1;
            adj_map[v2][s] = 1'b1;
            adj_map[s][v2] = 1'b1;
            edge_tbl[r.first_idx] = {v1, q};
            edge_tbl[r.second_idx] = r.orient ? {v2, v4} : {v3, v2};
            if (swap_count != '1) swap_count = swap_count + 1'b1;
            res.status = ST_SWAPPED;
          end
          {res.node_a, res.node_b} = edge_tbl[r.first_idx];
        end
      end
      default: begin
      end
    endcase
    res.total = swap_count;
    return res;
  endfunction

  function automatic dir_row_t dir_row(logic [OpW-1:0] op, int fi, int si, int ori,
                                       int na, int nb, bit typed = 1'b0,
                                       dpes_status_e st = ST_DONE, int ea = 0,
                                       int eb = 0, int tot = 0);
    dir_row_t d;
    d.req.op         = op;
    d.req.first_idx  = IndexW'(fi);
    d.req.second_idx = IndexW'(si);
    d.req.orient     = 1'(ori);
    d.req.node_a     = NodeFldW'(na);
    d.req.node_b     = NodeFldW'(nb);
    d.typed          = typed;
    d.res.status     = st;
    d.res.node_a     = NodeFldW'(ea);
    d.res.node_b     = NodeFldW'(eb);
    d.res.total      = CountW'(tot);
    return d;
  endfunction

  // Picks an edge that has been loaded and is below edge_count
  function automatic bit pick_loaded(output logic [IndexW-1:0] idx);
    int k;
    idx = '0;
    if (loaded_list.size() == 0) return 1'b0;
    for (int t = 0; t < 16; t++) begin
      k = $urandom_range(0, loaded_list.size() - 1);
      if (loaded_list[k] < int'(edge_count_cfg)) begin
        idx = IndexW'(loaded_list[k]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Mostly loads into a small window and swaps/reads of loaded edges;
  // a few unused opcodes and out-of-range indices
  function automatic graph_req_t make_random_req();
    graph_req_t r;
    int lim, win, roll;
    bit small_nodes;
    logic [IndexW-1:0] pi, pj;
    lim  = int'(edge_count_cfg);
    win  = (lim < LoadWindow) ? lim : LoadWindow;
    roll = $urandom_range(0, 99);
    small_nodes  = 1'($urandom);
    r.op         = OP_LOAD;
    r.first_idx  = IndexW'($urandom);
    r.second_idx = IndexW'($urandom);
    r.orient     = 1'($urandom);
    r.node_a     = small_nodes ? NodeFldW'($urandom_range(0, 15)) : NodeFldW'($urandom);
    r.node_b     = small_nodes ? NodeFldW'($urandom_range(0, 15)) : NodeFldW'($urandom);
    if (roll < 8) begin
      if (roll < 4 || lim >= DefMaxEdges) begin
        r.op = OpUnused;
      end else begin
        r.op = OpW'($urandom_range(0, 2));
        if (r.op == OP_SWAP && $urandom_range(0, 1) == 0)
          r.second_idx = IndexW'($urandom_range(lim, DefMaxEdges - 1));
        else
          r.first_idx = IndexW'($urandom_range(lim, DefMaxEdges - 1));
      end
      return r;
    end
    if (roll >= 35 && pick_loaded(pi)) begin
      r.first_idx = pi;
      if (roll < 50) begin
        r.op = OP_READ;
        return r;
      end
      if (pick_loaded(pj)) begin
        r.op = OP_SWAP;
        r.second_idx = pj;
        return r;
      end
    end
    // load
    r.op = OP_LOAD;
    if ($urandom_range(0, 99) < 85)
      r.first_idx = IndexW'($urandom_range(0, win - 1));
    else
      r.first_idx = IndexW'($urandom_range(0, lim - 1));
    return r;
  endfunction

  // Presents one request, waits for its transfer and records the expectation
  task automatic issue_request(graph_req_t r, logic typed, swap_result_t typed_res);
    swap_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    opcode_i            <= r.op;
    first_edge_index_i  <= r.first_idx;
    second_edge_index_i <= r.second_idx;
    orientation_i       <= r.orient;
    load_node_a_i       <= r.node_a;
    load_node_b_i       <= r.node_b;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    pred = apply_graph_op(r);
    expected_q.insert(expected_q.size(), typed ? typed_res : pred);
    items_sent++;
    // idling: receiver-heavy, then sender-heavy, then none
    if (items_sent == 520) begin
      send_idle_pct = 56;
      recv_idle_pct = 38;
    end else if (items_sent == 1040) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_edge_count(int value);
    cfg_valid_i      <= 1'b1;
    cfg_edge_count_i <= CfgW'(value);
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    edge_count_cfg = CfgW'(value);
  endtask

  // Result side: random stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    swap_result_t exp_res;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected result: status %0d a %0d b %0d total %0d",
                   status_o, edge_node_a_o, edge_node_b_o, swap_total_o);
      end else begin
        exp_res = expected_q.pop_front();
        if (status_o !== exp_res.status || edge_node_a_o !== exp_res.node_a ||
            edge_node_b_o !== exp_res.node_b || swap_total_o !== exp_res.total) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     exp_res.status, exp_res.node_a, exp_res.node_b, exp_res.total,
                     status_o, edge_node_a_o, edge_node_b_o, swap_total_o);
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    dir_tab = '{
      // both ends of the index and node ranges, checked by hand
      dir_row(OP_LOAD, 0, 0, 0, 0, 1, 1'b1, ST_DONE, 0, 1, 0),
      dir_row(OP_LOAD, 4095, 4095, 1, 255, 254, 1'b1, ST_DONE, 255, 254, 0),
      dir_row(OP_LOAD, 1, 0, 0, 2, 3, 1'b1, ST_DONE, 2, 3, 0),
      dir_row(OP_READ, 4095, 0, 0, 0, 0, 1'b1, ST_DONE, 255, 254, 0),
      // unused opcode
      dir_row(OpUnused, 4095, 4095, 1, 255, 255, 1'b1, ST_RANGE, 0, 0, 0),
      // 0-1 with 2-3 into 0-2 and 1-3
      dir_row(OP_SWAP, 0, 1, 1, 0, 0),
      dir_row(OP_READ, 1, 0, 0, 0, 0),
      // an edge swapped with itself
      dir_row(OP_SWAP, 0, 0, 0, 0, 0),
      // common endpoint
      dir_row(OP_LOAD, 2, 0, 0, 0, 5),
      dir_row(OP_SWAP, 0, 2, 0, 0, 0),
      // 8-9 and 10-11 with 8-10 present: one orientation blocked, other goes
      dir_row(OP_LOAD, 5, 0, 0, 8, 9),
      dir_row(OP_LOAD, 6, 0, 0, 10, 11),
      dir_row(OP_LOAD, 7, 0, 0, 8, 10),
      dir_row(OP_SWAP, 5, 6, 1, 0, 0),
      dir_row(OP_SWAP, 5, 6, 0, 0, 0),
      // self-loop
      dir_row(OP_LOAD, 8, 0, 0, 12, 12),
      dir_row(OP_READ, 8, 0, 0, 0, 0),
      // overwritten entry keeps its old bits: 14-12 stays in the bitmap
      dir_row(OP_LOAD, 12, 0, 0, 14, 12),
      dir_row(OP_LOAD, 12, 0, 0, 30, 31),
      dir_row(OP_LOAD, 8, 0, 0, 13, 14),
      dir_row(OP_LOAD, 11, 0, 0, 12, 15),
      dir_row(OP_SWAP, 8, 11, 0, 0, 0),
      dir_row(OP_SWAP, 8, 11, 1, 0, 0),
      dir_row(OP_READ, 11, 0, 0, 0, 0)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs with edge_count at its reset value
    foreach (dir_tab[k]) issue_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].res);

    // random phases, each under its own edge_count
    for (int p = 0; p < NumPhases; p++) begin
      wait_for_results();
      write_edge_count(phase_edges[p]);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 0 && n == phase_len[0] / 2) wait_for_results();
        issue_request(make_random_req(), 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (EndSlack) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/dpes_pkg.sv
rtl/core/dpes_ram.sv
rtl/core/dpes_ctrl.sv
rtl/core/dpes_datapath.sv
rtl/core/degree_preserving_edge_swap.sv
tb/sv/tb_degree_preserving_edge_swap.sv
